// File: hdl/bct_pkg.sv
// bct_pkg: shared types, codes and constants for the contour tracer
// no dependencies; imported by bct_ctrl, bct_dp and binary_contour_tracer_core
package bct_pkg;

  // coordinate width of the ports and of corner points
  localparam int CW = 9;

  // default store sizes
  localparam int DEF_MAX_WIDTH  = 256;
  localparam int DEF_MAX_HEIGHT = 256;

  // reset value of the size registers
  localparam logic [CW-1:0] SIZE_RESET = 9'd256;

  // item kinds
  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_FETCH = 1'b1;

  // configuration register indexes
  localparam logic CFG_WIDTH  = 1'b0;
  localparam logic CFG_HEIGHT = 1'b1;

  // headings
  localparam logic [1:0] HEAD_N = 2'd0;
  localparam logic [1:0] HEAD_E = 2'd1;
  localparam logic [1:0] HEAD_S = 2'd2;
  localparam logic [1:0] HEAD_W = 2'd3;

  typedef struct packed {
    logic          kind;
    logic [CW-1:0] pixel_x;
    logic [CW-1:0] pixel_y;
    logic          pixel_black;
  } in_item_t;

  typedef struct packed {
    logic [CW-1:0] corner_x;
    logic [CW-1:0] corner_y;
    logic          contour_end;
    logic          all_done;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DISP,
    ST_BLD_RD,
    ST_BLD_WR,
    ST_SCAN_RD,
    ST_SCAN_CK,
    ST_DONE,
    ST_STEP_A,
    ST_STEP_B
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic pix_wr;
    logic bld_init;
    logic bld_wr;
    logic scan_init;
    logic scan_adv;
    logic open;
    logic emit_cur;
    logic emit_close;
    logic emit_done;
    logic step_a;
    logic step_b;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic pix_in;
    logic bld_last;
    logic scan_hit;
    logic scan_last;
    logic close_now;
    logic out_free;
  } sts_t;

endpackage

// File: hdl/bct_ctrl.sv
// bct_ctrl: sequencer for pixel loads, mask build, start scan and boundary steps
// depends on bct_pkg; drives bct_dp through cmd_t and reads sts_t
module bct_ctrl import bct_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  input  logic     in_kind,
  output logic     in_stall,
  input  logic     cfg_valid,
  output logic     cfg_ready,
  input  sts_t     sts,
  output cmd_t     cmd
);

  state_t state, state_next;
  logic   mask_built, mask_built_next;
  logic   tracing, tracing_next;
  logic   closing, closing_next;

  // state and flags
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      mask_built <= 1'b0;
      tracing    <= 1'b0;
      closing    <= 1'b0;
    end else begin
      state      <= state_next;
      mask_built <= mask_built_next;
      tracing    <= tracing_next;
      closing    <= closing_next;
    end
  end

  assign in_stall  = (state != ST_IDLE);
  assign cfg_ready = (state == ST_IDLE);

  // next state and commands
  always_comb begin
    state_next      = state;
    mask_built_next = mask_built;
    tracing_next    = tracing;
    closing_next    = closing;
    cmd             = '0;
    case (state)
      ST_IDLE: begin
        if (cfg_valid) begin
          mask_built_next = 1'b0;
          tracing_next    = 1'b0;
          closing_next    = 1'b0;
        end
        if (in_valid) begin
          if (in_kind == KIND_WRITE) begin
            cmd.pix_wr = 1'b1;
            if (sts.pix_in) begin
              mask_built_next = 1'b0;
              tracing_next    = 1'b0;
              closing_next    = 1'b0;
            end
          end else if (!mask_built) begin
            cmd.bld_init = 1'b1;
            state_next   = ST_BLD_RD;
          end else if (closing) begin
            if (sts.out_free) begin
              cmd.emit_close = 1'b1;
              closing_next   = 1'b0;
              tracing_next   = 1'b0;
            end else begin
              state_next = ST_DISP;
            end
          end else if (tracing && sts.out_free) begin
            cmd.emit_cur = 1'b1;
            state_next   = ST_STEP_A;
          end else begin
            state_next = ST_DISP;
          end
        end
      end
      ST_DISP: begin
        if (closing) begin
          if (sts.out_free) begin
            cmd.emit_close = 1'b1;
            closing_next   = 1'b0;
            tracing_next   = 1'b0;
            state_next     = ST_IDLE;
          end
        end else if (!tracing) begin
          state_next = ST_SCAN_RD;
        end else if (sts.out_free) begin
          cmd.emit_cur = 1'b1;
          state_next   = ST_STEP_A;
        end
      end
      ST_BLD_RD: begin
        state_next = ST_BLD_WR;
      end
      ST_BLD_WR: begin
        cmd.bld_wr = 1'b1;
        if (sts.bld_last) begin
          mask_built_next = 1'b1;
          tracing_next    = 1'b0;
          closing_next    = 1'b0;
          cmd.scan_init   = 1'b1;
          state_next      = ST_DISP;
        end else begin
          state_next = ST_BLD_RD;
        end
      end
      ST_SCAN_RD: begin
        state_next = ST_SCAN_CK;
      end
      ST_SCAN_CK: begin
        if (sts.scan_hit) begin
          cmd.open     = 1'b1;
          tracing_next = 1'b1;
          state_next   = ST_DISP;
        end else if (sts.scan_last) begin
          state_next = ST_DONE;
        end else begin
          cmd.scan_adv = 1'b1;
          state_next   = ST_SCAN_RD;
        end
      end
      ST_DONE: begin
        if (sts.out_free) begin
          cmd.emit_done = 1'b1;
          state_next    = ST_IDLE;
        end
      end
      ST_STEP_A: begin
        cmd.step_a = 1'b1;
        state_next = ST_STEP_B;
      end
      ST_STEP_B: begin
        cmd.step_b = 1'b1;
        if (sts.close_now) closing_next = 1'b1;
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// File: hdl/bct_dp.sv
// bct_dp: image and start-mask bit stores, size registers, tracer coordinates
// and the output register; depends on bct_pkg, commanded by bct_ctrl
module bct_dp import bct_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic      clk,
  input  logic      rst,
  input  in_item_t  in_item,
  input  logic      cfg_wr,
  input  logic      cfg_index,
  input  logic [CW-1:0] cfg_data,
  input  cmd_t      cmd,
  output sts_t      sts,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item
);

  localparam int XW    = $clog2(MAX_WIDTH);
  localparam int YW    = $clog2(MAX_HEIGHT);
  localparam int AW    = XW + YW;
  localparam int DEPTH = 2 ** AW;

  // pixel (x,y), 1-based, to store address
  function automatic logic [AW-1:0] pix_addr(input logic [CW:0] px, input logic [CW:0] py);
    logic [CW:0] xm;
    logic [CW:0] ym;
    xm = px - 10'd1;
    ym = py - 10'd1;
    return {YW'(ym), XW'(xm)};
  endfunction

  logic [CW-1:0] width_reg, height_reg;
  logic [CW-1:0] eff_w, eff_h;

  // size registers
  always_ff @(posedge clk) begin
    if (rst) begin
      width_reg  <= SIZE_RESET;
      height_reg <= SIZE_RESET;
    end else if (cfg_wr) begin
      if (cfg_index == CFG_WIDTH) width_reg <= cfg_data;
      else                        height_reg <= cfg_data;
    end
  end

  // effective size, clamped to 1..max
  always_comb begin
    if (width_reg == '0)                eff_w = 9'd1;
    else if (int'(width_reg) > MAX_WIDTH) eff_w = CW'(MAX_WIDTH);
    else                                eff_w = width_reg;
    if (height_reg == '0)                 eff_h = 9'd1;
    else if (int'(height_reg) > MAX_HEIGHT) eff_h = CW'(MAX_HEIGHT);
    else                                  eff_h = height_reg;
  end

  function automatic logic inside_img(input logic [CW:0] px, input logic [CW:0] py,
                                      input logic [CW-1:0] w, input logic [CW-1:0] h);
    return (px != '0) && (py != '0) && (px <= {1'b0, w}) && (py <= {1'b0, h});
  endfunction

  logic [CW-1:0] bld_x, bld_y;
  logic [CW-1:0] scan_x, scan_y;
  logic [CW-1:0] cur_x, cur_y, start_x, start_y;
  logic [1:0]    heading;

  // next corner and the two neighbour pixels for a step
  logic [CW-1:0] ncx, ncy;
  logic [CW:0]   lx, ly, rx, ry, ex, ey;
  always_comb begin
    ncx = cur_x;
    ncy = cur_y;
    case (heading)
      HEAD_N:  ncy = cur_y - 9'd1;
      HEAD_E:  ncx = cur_x + 9'd1;
      HEAD_S:  ncy = cur_y + 9'd1;
      default: ncx = cur_x - 9'd1;
    endcase
    case (heading)
      HEAD_N: begin
        rx = {1'b0, ncx} + 10'd1; ry = {1'b0, ncy};
        lx = {1'b0, ncx};         ly = {1'b0, ncy};
      end
      HEAD_E: begin
        rx = {1'b0, ncx} + 10'd1; ry = {1'b0, ncy} + 10'd1;
        lx = {1'b0, ncx} + 10'd1; ly = {1'b0, ncy};
      end
      HEAD_S: begin
        rx = {1'b0, ncx};         ry = {1'b0, ncy} + 10'd1;
        lx = {1'b0, ncx} + 10'd1; ly = {1'b0, ncy} + 10'd1;
      end
      default: begin
        rx = {1'b0, ncx};         ry = {1'b0, ncy};
        lx = {1'b0, ncx};         ly = {1'b0, ncy} + 10'd1;
      end
    endcase
    // pixel passed by an east move
    ex = {1'b0, cur_x} + 10'd1;
    ey = {1'b0, cur_y} + 10'd1;
  end

  // image store: one write port, two registered read ports
  logic          img [DEPTH];
  logic [AW-1:0] img_ra, img_rb;
  logic          in_a, in_b;
  logic          rd_a, rd_b, in_a_q, in_b_q;
  logic [CW:0]   wx, wy;

  assign wx = {1'b0, in_item.pixel_x};
  assign wy = {1'b0, in_item.pixel_y};
  assign sts.pix_in = inside_img(wx, wy, eff_w, eff_h);

  always_comb begin
    if (cmd.step_a) begin
      img_ra = pix_addr(lx, ly);
      img_rb = pix_addr(rx, ry);
      in_a   = inside_img(lx, ly, eff_w, eff_h);
      in_b   = inside_img(rx, ry, eff_w, eff_h);
    end else begin
      img_ra = pix_addr({1'b0, bld_x}, {1'b0, bld_y});
      img_rb = pix_addr({1'b0, bld_x}, {1'b0, bld_y} - 10'd1);
      in_a   = 1'b1;
      in_b   = (bld_y != 9'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.pix_wr && sts.pix_in) img[pix_addr(wx, wy)] <= in_item.pixel_black;
    rd_a   <= img[img_ra];
    rd_b   <= img[img_rb];
    in_a_q <= in_a;
    in_b_q <= in_b;
  end

  // start mask: one write port, one registered read port at the scan position
  logic          msk [DEPTH];
  logic          msk_we, msk_wd, msk_rd;
  logic [AW-1:0] msk_wa;

  always_comb begin
    msk_we = 1'b0;
    msk_wd = 1'b0;
    msk_wa = pix_addr({1'b0, bld_x}, {1'b0, bld_y});
    if (cmd.bld_wr) begin
      msk_we = 1'b1;
      msk_wd = rd_a && !(rd_b && in_b_q);
    end else if (cmd.open) begin
      msk_we = 1'b1;
      msk_wa = pix_addr({1'b0, scan_x}, {1'b0, scan_y});
    end else if (cmd.step_a && heading == HEAD_E && inside_img(ex, ey, eff_w, eff_h)) begin
      msk_we = 1'b1;
      msk_wa = pix_addr(ex, ey);
    end
  end

  always_ff @(posedge clk) begin
    if (msk_we) msk[msk_wa] <= msk_wd;
    msk_rd <= msk[pix_addr({1'b0, scan_x}, {1'b0, scan_y})];
  end

  // build and scan counters, raster order
  assign sts.bld_last  = (bld_x == eff_w) && (bld_y == eff_h);
  assign sts.scan_last = (scan_x == eff_w) && (scan_y == eff_h);
  assign sts.scan_hit  = msk_rd;

  always_ff @(posedge clk) begin
    if (cmd.bld_init) begin
      bld_x <= 9'd1;
      bld_y <= 9'd1;
    end else if (cmd.bld_wr) begin
      if (bld_x == eff_w) begin
        bld_x <= 9'd1;
        bld_y <= bld_y + 9'd1;
      end else begin
        bld_x <= bld_x + 9'd1;
      end
    end
    if (cmd.scan_init) begin
      scan_x <= 9'd1;
      scan_y <= 9'd1;
    end else if (cmd.scan_adv) begin
      if (scan_x == eff_w) begin
        scan_x <= 9'd1;
        scan_y <= scan_y + 9'd1;
      end else begin
        scan_x <= scan_x + 9'd1;
      end
    end
  end

  // turn decision
  logic       left, right;
  logic [1:0] head_new;
  always_comb begin
    left  = rd_a && in_a_q;
    right = rd_b && in_b_q;
    if (left)        head_new = heading + 2'd3;
    else if (!right) head_new = heading + 2'd1;
    else             head_new = heading;
  end
  assign sts.close_now = (cur_x == start_x) && (cur_y == start_y) && (head_new == HEAD_E);

  // contour position and heading
  always_ff @(posedge clk) begin
    if (rst) begin
      heading <= HEAD_E;
    end else if (cmd.open) begin
      heading <= HEAD_E;
    end else if (cmd.step_b) begin
      heading <= head_new;
    end
    if (cmd.open) begin
      start_x <= scan_x - 9'd1;
      start_y <= scan_y - 9'd1;
      cur_x   <= scan_x - 9'd1;
      cur_y   <= scan_y - 9'd1;
    end else if (cmd.step_a) begin
      cur_x <= ncx;
      cur_y <= ncy;
    end
  end

  // output register
  assign sts.out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit_cur || cmd.emit_close || cmd.emit_done) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
    if (cmd.emit_cur) begin
      out_item <= '{corner_x: cur_x, corner_y: cur_y, contour_end: 1'b0, all_done: 1'b0};
    end else if (cmd.emit_close) begin
      out_item <= '{corner_x: start_x, corner_y: start_y, contour_end: 1'b1, all_done: 1'b0};
    end else if (cmd.emit_done) begin
      out_item <= '{corner_x: '0, corner_y: '0, contour_end: 1'b0, all_done: 1'b1};
    end
  end

endmodule

// File: hdl/binary_contour_tracer_core.sv
// binary contour tracer: a pixel write is taken in the idle state; a fetch on an open contour
// passes one image read of the two neighbour pixels (STEP_A) and one turn decision (STEP_B)
// first fetch after a change builds the start mask, with a read and a write state per pixel
// an opening scan has a read and a check state per mask pixel visited, one mask read port
// one beat of result may wait in the output register while the next item is taken
// synchronous reset clears control and sizes (256x256); image store is not cleared
module binary_contour_tracer_core import bct_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  in_item_t      in_item,
  output logic          out_valid,
  input  logic          out_stall,
  output out_item_t     out_item,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic          cfg_index,
  input  logic [CW-1:0] cfg_data
);

  cmd_t cmd;
  sts_t sts;

  // sequencer
  bct_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_kind   (in_item.kind),
    .in_stall  (in_stall),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // stores and coordinates
  bct_dp #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_item   (in_item),
    .cfg_wr    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule

// File: tb/binary_contour_tracer_core_tb.sv
// self-checking testbench for binary_contour_tracer_core: a queue-fed driver, a monitor
// and a bit-level predictor of the tracer; depends on bct_pkg and the core RTL only
`timescale 1ns / 100ps

module binary_contour_tracer_core_tb;
  import bct_pkg::*;

  localparam int SIDE       = 256;
  localparam int BLOCK      = 8;
  localparam int IDLE_LIMIT = 40000;
  localparam int SETTLE     = 16;
  localparam int RAND_ITEMS = 250;

  logic          clk;
  logic          rst;
  logic          in_valid;
  logic          in_stall;
  in_item_t      in_item;
  logic          out_valid;
  logic          out_stall;
  out_item_t     out_item;
  logic          cfg_valid;
  logic          cfg_ready;
  logic          cfg_index;
  logic [CW-1:0] cfg_data;

  binary_contour_tracer_core dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
    .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // pending beats and expected corner points
  in_item_t  pixel_q[$];
  out_item_t corner_q[$];

  int errors;
  int idle_cycles;
  int rand_items;
  int contours_seen;
  int points_seen;
  bit took;
  bit saw_done;

  // predictor state
  bit            img[SIDE*SIDE];
  bit            smask[SIDE*SIDE];
  logic [CW-1:0] reg_w, reg_h;
  bit            built, tracing, closing;
  logic [CW-1:0] cx, cy, sx, sy, scx, scy;
  logic [1:0]    hd;

  function automatic int eff_w();
    int w;
    w = reg_w;
    if (w < 1) w = 1;
    if (w > SIDE) w = SIDE;
    return w;
  endfunction

  function automatic int eff_h();
    int h;
    h = reg_h;
    if (h < 1) h = 1;
    if (h > SIDE) h = SIDE;
    return h;
  endfunction

  function automatic bit in_frame(int x, int y);
    return x >= 1 && y >= 1 && x <= eff_w() && y <= eff_h();
  endfunction

  function automatic int addr(int x, int y);
    return (y - 1) * SIDE + (x - 1);
  endfunction

  function automatic bit black_at(int x, int y);
    return in_frame(x, y) ? img[addr(x, y)] : 1'b0;
  endfunction

  function automatic bit start_at(int x, int y);
    return in_frame(x, y) ? smask[addr(x, y)] : 1'b0;
  endfunction

  function automatic void build_starts();
    for (int i = 0; i < SIDE*SIDE; i++) smask[i] = 1'b0;
    for (int y = 1; y <= eff_h(); y++)
      for (int x = 1; x <= eff_w(); x++)
        if (black_at(x, y) && !black_at(x, y - 1)) smask[addr(x, y)] = 1'b1;
    built = 1; tracing = 0; closing = 0;
    scx = 9'd1; scy = 9'd1;
  endfunction

  // raster scan from the last start for the next open start pixel
  function automatic bit find_start();
    int x, y;
    x = scx;
    for (y = scy; y <= eff_h(); y++) begin
      for (; x <= eff_w(); x++) begin
        if (start_at(x, y)) begin
          scx = CW'(x); scy = CW'(y);
          smask[addr(x, y)] = 1'b0;
          sx = CW'(x - 1); sy = CW'(y - 1);
          cx = sx; cy = sy;
          hd = HEAD_E;
          tracing = 1;
          return 1'b1;
        end
      end
      x = 1;
    end
    return 1'b0;
  endfunction

  // one move along the boundary, then the turn decision
  function automatic void walk_edge();
    int x, y;
    bit rt, lt;
    if (hd == HEAD_E && in_frame(cx + 1, cy + 1)) smask[addr(cx + 1, cy + 1)] = 1'b0;
    case (hd)
      HEAD_N: cy = cy - 1'b1;
      HEAD_E: cx = cx + 1'b1;
      HEAD_S: cy = cy + 1'b1;
      default: cx = cx - 1'b1;
    endcase
    x = cx; y = cy;
    case (hd)
      HEAD_N: begin rt = black_at(x + 1, y);     lt = black_at(x, y);         end
      HEAD_E: begin rt = black_at(x + 1, y + 1); lt = black_at(x + 1, y);     end
      HEAD_S: begin rt = black_at(x, y + 1);     lt = black_at(x + 1, y + 1); end
      default: begin rt = black_at(x, y);        lt = black_at(x, y + 1);     end
    endcase
    if (lt) hd = hd + 2'd3;
    else if (!rt) hd = hd + 2'd1;
    if (cx == sx && cy == sy && hd == HEAD_E) closing = 1;
  endfunction

  function automatic void predict_beat(in_item_t it);
    out_item_t o;
    if (it.kind == KIND_WRITE) begin
      if (in_frame(it.pixel_x, it.pixel_y)) begin
        img[addr(it.pixel_x, it.pixel_y)] = it.pixel_black;
        built = 0; tracing = 0; closing = 0;
      end
      return;
    end
    if (!built) build_starts();
    o = '0;
    if (closing) begin
      o.corner_x = sx; o.corner_y = sy; o.contour_end = 1'b1;
      closing = 0; tracing = 0;
      contours_seen++;
    end else if (!tracing && !find_start()) begin
      o.all_done = 1'b1;
      saw_done = 1;
    end else begin
      o.corner_x = cx; o.corner_y = cy;
      points_seen++;
      walk_edge();
    end
    corner_q.push_back(o);
  endfunction

  // clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // driver: accept at the rising edge, present the next beat at the falling edge
  int burst_left, gap_left;

  always @(posedge clk) begin
    took = 1'b0;
    if (!rst && in_valid && !in_stall) begin
      predict_beat(pixel_q.pop_front());
      took = 1'b1;
    end
  end

  always @(negedge clk) begin
    if (!rst && !(in_valid && !took)) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (pixel_q.size() > 0) begin
        in_valid <= 1'b1;
        in_item  <= pixel_q[0];
        if (burst_left > 0) burst_left--;
        else begin
          burst_left = $urandom_range(1, 40);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver stall pattern: modes of none, light and heavy stalling
  int stall_mode, mode_left;

  always @(negedge clk) begin
    if (mode_left == 0) begin
      stall_mode = $urandom_range(0, 2);
      mode_left  = $urandom_range(20, 200);
    end else mode_left--;
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 2) == 0);
      default: out_stall <= ($urandom_range(0, 3) != 0);
    endcase
  end

  // monitor
  always @(posedge clk) begin
    out_item_t want;
    if (!rst && out_valid && !out_stall) begin
      if (corner_q.size() == 0) begin
        $display("%0t: unexpected beat %p", $time, out_item);
        errors++;
      end else begin
        want = corner_q.pop_front();
        if (out_item.corner_x !== want.corner_x) begin
          $display("%0t: corner_x expected %0d got %0d", $time, want.corner_x,
                   out_item.corner_x);
          errors++;
        end
        if (out_item.corner_y !== want.corner_y) begin
          $display("%0t: corner_y expected %0d got %0d", $time, want.corner_y,
                   out_item.corner_y);
          errors++;
        end
        if (out_item.contour_end !== want.contour_end) begin
          $display("%0t: contour_end expected %0b got %0b", $time, want.contour_end,
                   out_item.contour_end);
          errors++;
        end
        if (out_item.all_done !== want.all_done) begin
          $display("%0t: all_done expected %0b got %0b", $time, want.all_done,
                   out_item.all_done);
          errors++;
        end
      end
    end
  end

  // watchdog on cycles with no beat on any channel
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > IDLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic push_pixel(int x, int y, bit b);
    in_item_t it;
    it.kind = KIND_WRITE; it.pixel_x = CW'(x); it.pixel_y = CW'(y); it.pixel_black = b;
    pixel_q.push_back(it);
  endtask

  task automatic push_fetch();
    in_item_t it;
    it.kind = KIND_FETCH;
    it.pixel_x = CW'($urandom_range(0, 511)); it.pixel_y = CW'($urandom_range(0, 511));
    it.pixel_black = ($urandom_range(0, 1) == 1);
    pixel_q.push_back(it);
  endtask

  task automatic drain();
    while (pixel_q.size() > 0 || corner_q.size() > 0 || in_valid) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [CW-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1; cfg_index <= idx; cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_WIDTH) reg_w = val;
    else reg_h = val;
    built = 0; tracing = 0; closing = 0;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_size(int w, int h);
    drain();
    write_reg(CFG_WIDTH, CW'(w));
    write_reg(CFG_HEIGHT, CW'(h));
  endtask

  // fetch until the done beat, with occasional writes breaking into a trace when noisy
  task automatic trace_all(bit noisy, int w, int h);
    int n;
    saw_done = 0;
    n = 0;
    while (!saw_done && n < 3000) begin
      for (int i = 0; i < 6; i++) begin
        if (noisy && $urandom_range(0, 60) == 0) begin
          push_pixel($urandom_range(1, w), $urandom_range(1, h), $urandom_range(0, 1) == 1);
          rand_items++;
        end else if (noisy && $urandom_range(0, 40) == 0) begin
          push_pixel(0, $urandom_range(0, 256), 1'b1);
        end
        push_fetch();
        n++;
        if (noisy) rand_items++;
      end
      while (pixel_q.size() > 0) @(posedge clk);
      @(posedge clk);
    end
    push_fetch();
    if (noisy) rand_items++;
  endtask

  initial begin
    int w, h, pick;
    rst = 1'b1; in_valid = 1'b0; in_item = '0; out_stall = 1'b0;
    cfg_valid = 1'b0; cfg_index = CFG_WIDTH; cfg_data = '0;
    errors = 0; rand_items = 0; burst_left = 0; gap_left = 0;
    stall_mode = 0; mode_left = 0; contours_seen = 0; points_seen = 0;
    reg_w = SIZE_RESET; reg_h = SIZE_RESET;
    built = 0; tracing = 0; closing = 0;
    cx = '0; cy = '0; sx = '0; sy = '0; scx = '0; scy = '0; hd = HEAD_E;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // define every pixel that any later size can reach: sparse top row and left column,
    // dense corner block
    for (int x = 1; x <= SIDE; x++) push_pixel(x, 1, $urandom_range(0, 15) == 0);
    for (int y = 2; y <= SIDE; y++) push_pixel(1, y, $urandom_range(0, 15) == 0);
    for (int y = 2; y <= BLOCK; y++)
      for (int x = 2; x <= BLOCK; x++) push_pixel(x, y, $urandom_range(0, 1) == 1);

    // directed: solid 3x3 square in a 4x4 frame, ignored writes, ignored fetch fields
    set_size(4, 4);
    for (int y = 1; y <= 4; y++)
      for (int x = 1; x <= 4; x++) push_pixel(x, y, x < 4 && y < 4);
    push_pixel(0, 0, 1'b1);
    push_pixel(SIDE, SIDE, 1'b1);
    trace_all(1'b0, 4, 4);
    push_fetch();
    // ring with a hole, and a write part way through a trace
    push_pixel(2, 2, 1'b0);
    push_fetch(); push_fetch(); push_fetch();
    push_pixel(4, 4, 1'b1);
    trace_all(1'b0, 4, 4);

    // extremes of the size registers
    set_size(0, 0);
    trace_all(1'b0, 1, 1);
    set_size(511, 1);
    trace_all(1'b0, SIDE, 1);
    set_size(1, 300);
    trace_all(1'b0, 1, SIDE);
    set_size(SIDE, 1);
    trace_all(1'b0, SIDE, 1);

    // random phases: mostly small frames, a few of the extreme shapes
    while (rand_items < RAND_ITEMS) begin
      pick = $urandom_range(0, 19);
      if (pick == 0) begin w = $urandom_range(17, SIDE); h = 1; end
      else if (pick == 1) begin w = 1; h = $urandom_range(17, SIDE); end
      else if (pick == 2) begin w = BLOCK; h = BLOCK; end
      else begin w = $urandom_range(1, 7); h = $urandom_range(1, 7); end
      set_size(w, h);
      for (int i = $urandom_range(1, 12); i > 0; i--) begin
        push_pixel($urandom_range(1, w), $urandom_range(1, h), $urandom_range(0, 3) != 0);
        rand_items++;
      end
      if ($urandom_range(0, 5) == 0) push_pixel(w + 1, $urandom_range(1, 256), 1'b1);
      trace_all(1'b1, w, h);
    end

    drain();
    $display("run traced %0d contours over %0d corner points in frames from 1x1 to 256x1",
             contours_seen, points_seen);
    $display("with sizes clamped at both ends, ignored writes and edits inside open traces");
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
